[rtl/mer_pkg.sv]
package mer_pkg;

    localparam int RADIUS_BITS_DEF = 10;
    localparam int COORD_BITS_DEF  = 12;
    localparam int UPC_W           = 6;

    localparam logic CMD_START = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONE,
        PH_TWO,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        MA_RADX,
        MA_RADY,
        MA_RXSQ,
        MA_RYSQ,
        MA_HX,
        MA_YM
    } mul_a_t;

    typedef enum logic [3:0] {
        MB_RADX,
        MB_RADY,
        MB_CURX,
        MB_CURY,
        MB_ONE,
        MB_RYSQ,
        MB_PROD,
        MB_HX,
        MB_YM
    } mul_b_t;

    typedef enum logic [1:0] {
        ACC_NOP,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [2:0] {
        RO_NONE,
        RO_INIT_XY,
        RO_LOAD_RXSQ,
        RO_LOAD_RYSQ,
        RO_LOAD_TMP,
        RO_X_INC,
        RO_Y_DEC,
        RO_XY_STEP
    } reg_op_t;

    typedef enum logic [1:0] {
        PO_KEEP,
        PO_ONE,
        PO_TWO,
        PO_DONE
    } phase_op_t;

    typedef enum logic [2:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_DISPATCH,
        BR_DEC_NONNEG,
        BR_DEC_POS,
        BR_NOT_ONE,
        BR_LESS,
        BR_Y_NZ
    } branch_t;

    typedef struct packed {
        mul_a_t           ma;
        mul_b_t           mb;
        acc_op_t          acc;
        logic [1:0]       sh;
        reg_op_t          rop;
        phase_op_t        pop;
        branch_t          br;
        logic [UPC_W-1:0] target;
        logic             emit;
        logic             neg_x;
        logic             neg_y;
        logic             last;
    } ctrl_t;

    // microcode entry points
    localparam logic [UPC_W-1:0] UA_FETCH  = UPC_W'(0);
    localparam logic [UPC_W-1:0] UA_ST0    = UPC_W'(1);
    localparam logic [UPC_W-1:0] UA_R1A    = UPC_W'(6);
    localparam logic [UPC_W-1:0] UA_R1P0   = UPC_W'(10);
    localparam logic [UPC_W-1:0] UA_R2A    = UPC_W'(14);
    localparam logic [UPC_W-1:0] UA_R2P0   = UPC_W'(20);
    localparam logic [UPC_W-1:0] UA_SETTLE = UPC_W'(23);
    localparam logic [UPC_W-1:0] UA_S3     = UPC_W'(32);
    localparam logic [UPC_W-1:0] UA_EM0    = UPC_W'(34);

    function automatic ctrl_t cw(input mul_a_t ma, input mul_b_t mb, input acc_op_t acc,
                                 input logic [1:0] sh, input reg_op_t rop,
                                 input phase_op_t pop, input branch_t br,
                                 input logic [UPC_W-1:0] tg);
        ctrl_t w;
        w.ma     = ma;
        w.mb     = mb;
        w.acc    = acc;
        w.sh     = sh;
        w.rop    = rop;
        w.pop    = pop;
        w.br     = br;
        w.target = tg;
        w.emit   = 1'b0;
        w.neg_x  = 1'b0;
        w.neg_y  = 1'b0;
        w.last   = 1'b0;
        return w;
    endfunction

    function automatic ctrl_t ew(input logic nx, input logic ny, input logic lst,
                                 input branch_t br, input logic [UPC_W-1:0] tg);
        ctrl_t w;
        w       = cw(MA_RADX, MB_RADX, ACC_NOP, 2'd0, RO_NONE, PO_KEEP, br, tg);
        w.emit  = 1'b1;
        w.neg_x = nx;
        w.neg_y = ny;
        w.last  = lst;
        return w;
    endfunction

    function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        case (addr)
            // fetch and dispatch
            UPC_W'(0):  w = cw(MA_RADX, MB_RADX, ACC_NOP, 2'd0, RO_NONE, PO_KEEP,
                               BR_DISPATCH, UA_FETCH);
            // start: squares and region-one decision
            UPC_W'(1):  w = cw(MA_RADX, MB_RADX, ACC_NOP, 2'd0, RO_INIT_XY, PO_ONE,
                               BR_NEXT, UA_FETCH);
            UPC_W'(2):  w = cw(MA_RADY, MB_RADY, ACC_NOP, 2'd0, RO_LOAD_RXSQ, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(3):  w = cw(MA_RXSQ, MB_RADY, ACC_LOAD, 2'd2, RO_LOAD_RYSQ, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(4):  w = cw(MA_RXSQ, MB_ONE, ACC_SUB, 2'd2, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(5):  w = cw(MA_RADX, MB_RADX, ACC_ADD, 2'd0, RO_NONE, PO_KEEP,
                               BR_ALWAYS, UA_SETTLE);
            // region one step
            UPC_W'(6):  w = cw(MA_RADX, MB_RADX, ACC_NOP, 2'd0, RO_X_INC, PO_KEEP,
                               BR_DEC_NONNEG, UA_R1P0);
            UPC_W'(7):  w = cw(MA_RYSQ, MB_CURX, ACC_NOP, 2'd0, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(8):  w = cw(MA_RYSQ, MB_ONE, ACC_ADD, 2'd3, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(9):  w = cw(MA_RADX, MB_RADX, ACC_ADD, 2'd2, RO_NONE, PO_KEEP,
                               BR_ALWAYS, UA_SETTLE);
            UPC_W'(10): w = cw(MA_RYSQ, MB_CURX, ACC_NOP, 2'd0, RO_Y_DEC, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(11): w = cw(MA_RXSQ, MB_CURY, ACC_ADD, 2'd3, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(12): w = cw(MA_RYSQ, MB_ONE, ACC_SUB, 2'd3, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(13): w = cw(MA_RADX, MB_RADX, ACC_ADD, 2'd2, RO_NONE, PO_KEEP,
                               BR_ALWAYS, UA_SETTLE);
            // region two step
            UPC_W'(14): w = cw(MA_RADX, MB_RADX, ACC_NOP, 2'd0, RO_NONE, PO_KEEP,
                               BR_DEC_POS, UA_R2P0);
            UPC_W'(15): w = cw(MA_RADX, MB_RADX, ACC_NOP, 2'd0, RO_XY_STEP, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(16): w = cw(MA_RYSQ, MB_CURX, ACC_NOP, 2'd0, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(17): w = cw(MA_RXSQ, MB_CURY, ACC_ADD, 2'd3, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(18): w = cw(MA_RXSQ, MB_ONE, ACC_SUB, 2'd3, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(19): w = cw(MA_RADX, MB_RADX, ACC_ADD, 2'd2, RO_NONE, PO_KEEP,
                               BR_ALWAYS, UA_SETTLE);
            UPC_W'(20): w = cw(MA_RXSQ, MB_ONE, ACC_NOP, 2'd0, RO_Y_DEC, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(21): w = cw(MA_RXSQ, MB_CURY, ACC_ADD, 2'd2, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(22): w = cw(MA_RADX, MB_RADX, ACC_SUB, 2'd3, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            // settle: region-one exit test
            UPC_W'(23): w = cw(MA_RYSQ, MB_CURX, ACC_NOP, 2'd0, RO_NONE, PO_KEEP,
                               BR_NOT_ONE, UA_S3);
            UPC_W'(24): w = cw(MA_RXSQ, MB_CURY, ACC_NOP, 2'd0, RO_LOAD_TMP, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(25): w = cw(MA_RADX, MB_RADX, ACC_NOP, 2'd0, RO_NONE, PO_KEEP,
                               BR_LESS, UA_EM0);
            // region-two decision setup
            UPC_W'(26): w = cw(MA_HX, MB_HX, ACC_NOP, 2'd0, RO_NONE, PO_TWO,
                               BR_NEXT, UA_FETCH);
            UPC_W'(27): w = cw(MA_RYSQ, MB_PROD, ACC_NOP, 2'd0, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(28): w = cw(MA_YM, MB_YM, ACC_LOAD, 2'd0, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(29): w = cw(MA_RXSQ, MB_PROD, ACC_NOP, 2'd0, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(30): w = cw(MA_RXSQ, MB_RYSQ, ACC_ADD, 2'd2, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            UPC_W'(31): w = cw(MA_RADX, MB_RADX, ACC_SUB, 2'd2, RO_NONE, PO_KEEP,
                               BR_NEXT, UA_FETCH);
            // settle: end of drawing
            UPC_W'(32): w = cw(MA_RADX, MB_RADX, ACC_NOP, 2'd0, RO_NONE, PO_KEEP,
                               BR_Y_NZ, UA_EM0);
            UPC_W'(33): w = cw(MA_RADX, MB_RADX, ACC_NOP, 2'd0, RO_NONE, PO_DONE,
                               BR_NEXT, UA_FETCH);
            // four symmetric points
            UPC_W'(34): w = ew(1'b0, 1'b0, 1'b0, BR_NEXT, UA_FETCH);
            UPC_W'(35): w = ew(1'b1, 1'b0, 1'b0, BR_NEXT, UA_FETCH);
            UPC_W'(36): w = ew(1'b0, 1'b1, 1'b0, BR_NEXT, UA_FETCH);
            UPC_W'(37): w = ew(1'b1, 1'b1, 1'b1, BR_ALWAYS, UA_FETCH);
            default:    w = cw(MA_RADX, MB_RADX, ACC_NOP, 2'd0, RO_NONE, PO_KEEP,
                               BR_ALWAYS, UA_FETCH);
        endcase
        return w;
    endfunction

endpackage

[rtl/midpoint_ellipse_rasterizer_core.sv]
// channel | dir | handshake          | tdata (low bit up)                      | tuser    | tlast
// s_      | in  | s_tvalid/s_tready  | center_x, center_y, radius_x, radius_y  | command  | -
// m_      | out | m_tvalid/m_tready  | point_x, point_y                        | finished | last_of_step
//
// one micro-op per cycle from a 38-word control store driving a single multiplier
// and a decision accumulator, except that the sequencer holds on the emit micro-op
// while the result side stalls; a step command while idle or done returns to fetch,
// and a start or a step that enters region two also runs the region-two decision setup
// a new command is taken once the fourth point sits in the output register
// aresetn is synchronous and active low; no clearing pass after reset
module midpoint_ellipse_rasterizer_core #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    localparam int S_TDATA_W  = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((2 * (COORD_BITS + 1) + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // center_x, center_y, radius_x, radius_y
    input  logic                 s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // point_x, point_y
    output logic                 m_tlast,
    output logic                 m_tuser    // finished
);
    import mer_pkg::*;

    localparam int AW    = 2 * RADIUS_BITS;
    localparam int BW    = 2 * RADIUS_BITS + 4;
    localparam int PW    = AW + BW;
    localparam int DEC_W = 4 * RADIUS_BITS + 8;
    localparam int XW    = RADIUS_BITS + 1;
    localparam int PT_W  = COORD_BITS + 1;
    localparam int SUM_W = ((COORD_BITS > XW) ? COORD_BITS : XW) + 2;

    logic [UPC_W-1:0]         upc_reg, upc_next;
    phase_t                   phase_reg, phase_next;
    logic signed [COORD_BITS-1:0] org_x_reg, org_y_reg;
    logic [RADIUS_BITS-1:0]   rad_x_reg, rad_y_reg;
    logic [AW-1:0]            rx_sq_reg, ry_sq_reg;
    logic [XW-1:0]            cur_x_reg, cur_y_reg;
    logic signed [DEC_W-1:0]  dec_reg, dec_next;
    logic [PW-1:0]            prod_reg, tmp_reg;
    logic                     m_tvalid_reg;
    logic [PT_W-1:0]          pt_x_reg, pt_y_reg;
    logic                     last_reg, fin_reg;

    ctrl_t                    ctrl;
    logic                     in_xfer, out_free, stall;
    logic [AW-1:0]            mul_a;
    logic [BW-1:0]            mul_b;
    logic [PW-1:0]            mul_res;
    logic [XW:0]              hx;
    logic [XW-1:0]            ym_mag;
    logic signed [DEC_W-1:0]  acc_opnd;
    logic                     dec_neg, dec_pos;
    logic signed [SUM_W-1:0]  ox, oy, offx, offy, sum_x, sum_y;

    assign ctrl     = ucode_rom(upc_reg);
    assign s_tready = (upc_reg == UA_FETCH);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign stall    = ctrl.emit && !out_free;

    // multiplier operands
    assign hx     = {cur_x_reg, 1'b1};
    assign ym_mag = (cur_y_reg == '0) ? XW'(1) : cur_y_reg - XW'(1);

    always_comb begin
        case (ctrl.ma)
            MA_RADX: mul_a = AW'(rad_x_reg);
            MA_RADY: mul_a = AW'(rad_y_reg);
            MA_RXSQ: mul_a = rx_sq_reg;
            MA_RYSQ: mul_a = ry_sq_reg;
            MA_HX:   mul_a = AW'(hx);
            MA_YM:   mul_a = AW'(ym_mag);
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        case (ctrl.mb)
            MB_RADX: mul_b = BW'(rad_x_reg);
            MB_RADY: mul_b = BW'(rad_y_reg);
            MB_CURX: mul_b = BW'(cur_x_reg);
            MB_CURY: mul_b = BW'(cur_y_reg);
            MB_ONE:  mul_b = BW'(1);
            MB_RYSQ: mul_b = BW'(ry_sq_reg);
            MB_PROD: mul_b = prod_reg[BW-1:0];
            MB_HX:   mul_b = BW'(hx);
            MB_YM:   mul_b = BW'(ym_mag);
            default: mul_b = '0;
        endcase
    end

    assign mul_res = mul_a * mul_b;

    // decision accumulator
    assign acc_opnd = $signed(DEC_W'(prod_reg) << ctrl.sh);
    assign dec_neg  = dec_reg[DEC_W-1];
    assign dec_pos  = !dec_neg && (dec_reg != '0);

    always_comb begin
        case (ctrl.acc)
            ACC_NOP:  dec_next = dec_reg;
            ACC_LOAD: dec_next = acc_opnd;
            ACC_ADD:  dec_next = dec_reg + acc_opnd;
            ACC_SUB:  dec_next = dec_reg - acc_opnd;
            default:  dec_next = dec_reg;
        endcase
    end

    // sequencer next address
    always_comb begin
        upc_next = upc_reg + UPC_W'(1);
        case (ctrl.br)
            BR_NEXT:       upc_next = upc_reg + UPC_W'(1);
            BR_ALWAYS:     upc_next = ctrl.target;
            BR_DISPATCH: begin
                if (!s_tvalid) begin
                    upc_next = UA_FETCH;
                end else if (s_tuser == CMD_START) begin
                    upc_next = UA_ST0;
                end else if (phase_reg == PH_ONE) begin
                    upc_next = UA_R1A;
                end else if (phase_reg == PH_TWO) begin
                    upc_next = UA_R2A;
                end else begin
                    upc_next = UA_FETCH;
                end
            end
            BR_DEC_NONNEG: if (!dec_neg) upc_next = ctrl.target;
            BR_DEC_POS:    if (dec_pos) upc_next = ctrl.target;
            BR_NOT_ONE:    if (phase_reg != PH_ONE) upc_next = ctrl.target;
            BR_LESS:       if (tmp_reg < prod_reg) upc_next = ctrl.target;
            BR_Y_NZ:       if (cur_y_reg != '0) upc_next = ctrl.target;
            default:       upc_next = UA_FETCH;
        endcase
        if (stall) begin
            upc_next = upc_reg;
        end
    end

    always_comb begin
        case (ctrl.pop)
            PO_KEEP: phase_next = phase_reg;
            PO_ONE:  phase_next = PH_ONE;
            PO_TWO:  phase_next = PH_TWO;
            PO_DONE: phase_next = PH_DONE;
            default: phase_next = phase_reg;
        endcase
    end

    // point offsets
    assign ox    = SUM_W'(org_x_reg);
    assign oy    = SUM_W'(org_y_reg);
    assign offx  = $signed(SUM_W'(cur_x_reg));
    assign offy  = $signed(SUM_W'(cur_y_reg));
    assign sum_x = ctrl.neg_x ? (ox - offx) : (ox + offx);
    assign sum_y = ctrl.neg_y ? (oy - offy) : (oy + offy);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg      <= UA_FETCH;
            phase_reg    <= PH_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            upc_reg   <= upc_next;
            phase_reg <= phase_next;
            if (ctrl.emit && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_tuser == CMD_START) begin
            org_x_reg <= $signed(s_tdata[COORD_BITS-1:0]);
            org_y_reg <= $signed(s_tdata[2*COORD_BITS-1:COORD_BITS]);
            rad_x_reg <= s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
            rad_y_reg <= s_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];
        end
        prod_reg <= mul_res;
        dec_reg  <= dec_next;
        case (ctrl.rop)
            RO_NONE: begin
            end
            RO_INIT_XY: begin
                cur_x_reg <= '0;
                cur_y_reg <= XW'(rad_y_reg);
            end
            RO_LOAD_RXSQ: rx_sq_reg <= prod_reg[AW-1:0];
            RO_LOAD_RYSQ: ry_sq_reg <= prod_reg[AW-1:0];
            RO_LOAD_TMP:  tmp_reg   <= prod_reg;
            RO_X_INC:     cur_x_reg <= cur_x_reg + XW'(1);
            RO_Y_DEC:     cur_y_reg <= cur_y_reg - XW'(1);
            RO_XY_STEP: begin
                cur_x_reg <= cur_x_reg + XW'(1);
                cur_y_reg <= cur_y_reg - XW'(1);
            end
            default: begin
            end
        endcase
        if (ctrl.emit && out_free) begin
            pt_x_reg <= sum_x[PT_W-1:0];
            pt_y_reg <= sum_y[PT_W-1:0];
            last_reg <= ctrl.last;
            fin_reg  <= (phase_reg == PH_DONE);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({pt_y_reg, pt_x_reg});
    assign m_tlast  = last_reg;
    assign m_tuser  = fin_reg;

    a_done_y_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |-> cur_y_reg == '0)
        else $error("finished ellipse with nonzero y");

    a_one_y_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == UA_FETCH && phase_reg == PH_ONE) |-> cur_y_reg != '0)
        else $error("region one idle at y of zero");

    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.emit && !out_free) |=> $stable(upc_reg))
        else $error("sequencer moved past a blocked point");

    a_last_to_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.emit && out_free && ctrl.last) |=> upc_reg == UA_FETCH)
        else $error("fourth point not followed by fetch");

endmodule
